// File: hw/rtl/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Register indexes, field widths and pipeline types for the vertex transform
// and projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 3'd5;

    localparam logic [CFG_DATA_W-1:0] ROW_X_RST = 48'd256;
    localparam logic [CFG_DATA_W-1:0] ROW_Y_RST = 48'h0000_0100_0000;
    localparam logic [CFG_DATA_W-1:0] ROW_Z_RST = 48'h0100_0000_0000;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 72;
    localparam int QUOT_W     = 18;
    localparam int MAG_W      = 40;
    localparam int DIV_W      = 32;
    localparam int CMP_W      = 50;

    typedef struct packed {
        logic [MAG_W-1:0]  rx;
        logic [MAG_W-1:0]  ry;
        logic [QUOT_W-1:0] qx;
        logic [QUOT_W-1:0] qy;
        logic [DIV_W-1:0]  d;
        logic              sx;
        logic              sy;
        logic              ox;
        logic              oy;
        logic              vis;
        logic              last;
        logic [26:0]       camz;
        logic [7:0]        shade;
    } t_div;

endpackage

`default_nettype wire

// File: hw/rtl/vertex_transform_project.sv
// ----------------------------------------------------------------------------
// vertex_transform_project
// Rotates and offsets one vertex, projects it onto the screen with a
// pipelined divider and computes a clamped shade from the rotated normal.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata                           | tuser   | tlast
//  s (vert)  | in        | vx, vy, vz, nx, ny, nz          | -       | last_vertex
//  m (pixel) | out       | screen_x, screen_y, camz, shade | visible | last_out
//  cfg       | in        | write enable, index, 48-bit data
//
//  One beat is accepted per cycle while the output is not stalled; each beat
//  passes the product, sum, magnitude and setup stages, the 18 restoring divider steps and the output register.
//  Reset clears all valid bits and restores the identity matrix.
//  Each stage holds only while the next is full and stalled, so bubbles
//  close up and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_project #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [vtp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [vtp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // vert_x, vert_y, vert_z, norm_x, norm_y, norm_z (16 bits each)
    input  wire logic [vtp_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  wire logic                             i_s_tlast,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // screen_x 16, screen_y 16, camera_z 27, shade 8, zero pad 5
    output logic [vtp_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    // visible
    output logic                                  o_m_tuser,
    output logic                                  o_m_tlast
);
    import vtp_pkg::*;

    localparam int NST = 23;
    localparam int DST = 4;
    localparam logic signed [20:0] HALF_X = 21'(SCREEN_WIDTH / 2);
    localparam logic signed [20:0] HALF_Y = 21'(SCREEN_HEIGHT / 2);

    logic [CFG_DATA_W-1:0] r_row_x, r_row_y, r_row_z;
    logic signed [15:0]    r_off_x, r_off_y, r_off_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= ROW_X_RST;
            r_row_y <= ROW_Y_RST;
            r_row_z <= ROW_Z_RST;
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_X: r_row_x <= i_cfg_data;
                REG_ROW_Y: r_row_y <= i_cfg_data;
                REG_ROW_Z: r_row_z <= i_cfg_data;
                REG_OFF_X: r_off_x <= i_cfg_data[15:0];
                REG_OFF_Y: r_off_y <= i_cfg_data[15:0];
                REG_OFF_Z: r_off_z <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_vld[NST-1] || i_m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = en[0];

    // Stage 0: products.
    logic signed [31:0] r_px [3];
    logic signed [31:0] r_py [3];
    logic signed [31:0] r_pz [3];
    logic signed [31:0] r_pn [3];
    logic               r_last0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int c = 0; c < 3; c++) begin
                r_px[c] <= $signed(i_s_tdata[16*c +: 16]) * $signed(r_row_x[16*c +: 16]);
                r_py[c] <= $signed(i_s_tdata[16*c +: 16]) * $signed(r_row_y[16*c +: 16]);
                r_pz[c] <= $signed(i_s_tdata[16*c +: 16]) * $signed(r_row_z[16*c +: 16]);
                r_pn[c] <= $signed(i_s_tdata[48+16*c +: 16])
                         * $signed(r_row_z[16*c +: 16]);
            end
            r_last0 <= i_s_tlast;
        end
    end

    // Stage 1: sums.
    logic signed [32:0] r_cx, r_cy, r_cz, r_sh;
    logic               r_last1;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_cx <= 33'(r_px[0]) + 33'(r_px[1]) + 33'(r_px[2])
                  + (33'(r_off_x) <<< 8);
            r_cy <= 33'(r_py[0]) + 33'(r_py[1]) + 33'(r_py[2])
                  + (33'(r_off_y) <<< 8);
            r_cz <= 33'(r_pz[0]) + 33'(r_pz[1]) + 33'(r_pz[2])
                  + (33'(r_off_z) <<< 8);
            r_sh <= 33'(r_pn[0]) + 33'(r_pn[1]) + 33'(r_pn[2]);
            r_last1 <= r_last0;
        end
    end

    // Stage 2: magnitudes, depth and shade.
    logic [MAG_W-1:0] r_magx, r_magy;
    logic [DIV_W-1:0] r_d;
    logic             r_sx2, r_sy2, r_vis2, r_last2;
    logic [26:0]      r_camz2;
    logic [7:0]       r_shade2;
    logic [32:0]      absx, absy;
    logic [26:0]      camz_sat;
    logic [7:0]       shade_cl;

    always_comb begin
        absx = r_cx[32] ? 33'(-r_cx) : r_cx;
        absy = r_cy[32] ? 33'(-r_cy) : r_cy;
        if (r_cz[32:26] == 7'h00 || r_cz[32:26] == 7'h7f) begin
            camz_sat = r_cz[26:0];
        end else if (r_cz[32]) begin
            camz_sat = 27'h4000000;
        end else begin
            camz_sat = 27'h3ffffff;
        end
        if (r_sh[32]) begin
            shade_cl = '0;
        end else if (r_sh[31:16] != '0) begin
            shade_cl = 8'hff;
        end else begin
            shade_cl = r_sh[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_magx   <= {absx[31:0], 8'h00};
            r_magy   <= {absy[31:0], 8'h00};
            r_sx2    <= r_cx[32];
            r_sy2    <= r_cy[32];
            r_d      <= r_cz[31:0];
            r_vis2   <= !r_cz[32] && (r_cz != '0);
            r_camz2  <= camz_sat;
            r_shade2 <= shade_cl;
            r_last2  <= r_last1;
        end
    end

    // Stage 3: quotient overflow check and divider setup.
    t_div r_dv3;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_dv3.rx    <= r_magx;
            r_dv3.ry    <= r_magy;
            r_dv3.qx    <= '0;
            r_dv3.qy    <= '0;
            r_dv3.d     <= r_d;
            r_dv3.sx    <= r_sx2;
            r_dv3.sy    <= r_sy2;
            r_dv3.ox    <= CMP_W'(r_magx) >= {r_d, 18'd0};
            r_dv3.oy    <= CMP_W'(r_magy) >= {r_d, 18'd0};
            r_dv3.vis   <= r_vis2;
            r_dv3.last  <= r_last2;
            r_dv3.camz  <= r_camz2;
            r_dv3.shade <= r_shade2;
        end
    end

    // Stages 4 to 21: one quotient bit per stage, highest first.
    t_div r_div [QUOT_W];
    t_div n_div [QUOT_W];

    for (genvar j = 0; j < QUOT_W; j++) begin : g_div
        t_div            prev;
        logic [CMP_W-1:0] dsh;
        if (j == 0) begin : g_first
            assign prev = r_dv3;
        end else begin : g_next
            assign prev = r_div[j-1];
        end
        assign dsh = CMP_W'(prev.d) << (QUOT_W - 1 - j);
        always_comb begin
            n_div[j] = prev;
            if (CMP_W'(prev.rx) >= dsh) begin
                n_div[j].rx = MAG_W'(CMP_W'(prev.rx) - dsh);
                n_div[j].qx[QUOT_W-1-j] = 1'b1;
            end
            if (CMP_W'(prev.ry) >= dsh) begin
                n_div[j].ry = MAG_W'(CMP_W'(prev.ry) - dsh);
                n_div[j].qy[QUOT_W-1-j] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[DST+j]) begin
                r_div[j] <= n_div[j];
            end
        end
    end

    // Stage 22: sign, screen center, saturation.
    t_div               fin;
    logic signed [20:0] vx, vy;
    logic [15:0]        scr_x, scr_y;
    logic [15:0]        r_scr_x, r_scr_y;
    logic [26:0]        r_camz;
    logic [7:0]         r_shade;
    logic               r_vis, r_last;

    always_comb begin
        fin = r_div[QUOT_W-1];
        vx = (fin.sx ? -$signed(21'(fin.qx)) : $signed(21'(fin.qx))) + HALF_X;
        vy = (fin.sy ? -$signed(21'(fin.qy)) : $signed(21'(fin.qy))) + HALF_Y;
        if (!fin.vis) begin
            scr_x = '0;
        end else if (fin.ox) begin
            scr_x = fin.sx ? 16'h8000 : 16'h7fff;
        end else if (vx > 21'sd32767) begin
            scr_x = 16'h7fff;
        end else if (vx < -21'sd32768) begin
            scr_x = 16'h8000;
        end else begin
            scr_x = vx[15:0];
        end
        if (!fin.vis) begin
            scr_y = '0;
        end else if (fin.oy) begin
            scr_y = fin.sy ? 16'h8000 : 16'h7fff;
        end else if (vy > 21'sd32767) begin
            scr_y = 16'h7fff;
        end else if (vy < -21'sd32768) begin
            scr_y = 16'h8000;
        end else begin
            scr_y = vy[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_scr_x <= scr_x;
            r_scr_y <= scr_y;
            r_camz  <= fin.camz;
            r_shade <= fin.shade;
            r_vis   <= fin.vis;
            r_last  <= fin.last;
        end
    end

    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tdata  = {5'd0, r_shade, r_camz, r_scr_y, r_scr_x};
    assign o_m_tuser  = r_vis;
    assign o_m_tlast  = r_last;

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[31:0] == 32'd0)
        else $error("screen position not zero for a hidden vertex");

    a_vis_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser == ($signed(o_m_tdata[58:32]) > 27'sd0))
        else $error("visible flag disagrees with depth");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_m_tvalid)
        else $error("output valid right after reset");

    a_accept_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted beat not held in first stage");

endmodule

`default_nettype wire

// File: test/vertex_transform_project_tb.sv
// ----------------------------------------------------------------------------
// vertex_transform_project_tb
// Streams vertices through the transform and projection block under random
// source gaps and sink stalls, predicts every result from the configured
// matrix and position, and compares each output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class vertex_scoreboard;
    logic [71:0] pending_data[$];
    logic        pending_vis[$];
    logic        pending_last[$];
    int          errors;

    function void note_vertex(logic [71:0] d, logic vis, logic last);
        pending_data.push_back(d);
        pending_vis.push_back(vis);
        pending_last.push_back(last);
    endfunction

    function int check_pixel(logic [71:0] d, logic vis, logic last);
        logic [71:0] ed;
        logic        ev;
        logic        el;
        int          bad;
        bad = 0;
        if (pending_data.size() == 0) begin
            $display("ERROR: unexpected output beat %h", d);
            errors++;
            return 1;
        end
        ed = pending_data.pop_front();
        ev = pending_vis.pop_front();
        el = pending_last.pop_front();
        if (d[15:0] !== ed[15:0]) begin
            $display("ERROR: screen_x got %h exp %h", d[15:0], ed[15:0]); bad++;
        end
        if (d[31:16] !== ed[31:16]) begin
            $display("ERROR: screen_y got %h exp %h", d[31:16], ed[31:16]); bad++;
        end
        if (d[58:32] !== ed[58:32]) begin
            $display("ERROR: camera_z got %h exp %h", d[58:32], ed[58:32]); bad++;
        end
        if (d[66:59] !== ed[66:59]) begin
            $display("ERROR: shade got %h exp %h", d[66:59], ed[66:59]); bad++;
        end
        if (d[71:67] !== 5'd0) begin
            $display("ERROR: pad bits nonzero %h", d[71:67]); bad++;
        end
        if (vis !== ev) begin
            $display("ERROR: visible got %b exp %b", vis, ev); bad++;
        end
        if (last !== el) begin
            $display("ERROR: last got %b exp %b", last, el); bad++;
        end
        errors += bad;
        return bad;
    endfunction
endclass

module vertex_transform_project_tb;
    import vtp_pkg::*;

    localparam int SW = 320;
    localparam int SH = 240;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    vertex_transform_project #(.SCREEN_WIDTH(SW), .SCREEN_HEIGHT(SH)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    vertex_scoreboard sb = new();
    int mismatch_count = 0;
    bit sink_random = 1'b1;
    int sink_hold = 0;

    logic [47:0] row_x, row_y, row_z;
    logic [15:0] pos_x, pos_y, pos_z;

    task automatic report_mismatch(input int n);
        if (n != 0) begin
            $display("ERROR: %0d field mismatches at %0t", n, $time);
            mismatch_count++;
        end
    endtask

    function automatic longint row_dot(logic [47:0] row, longint a, longint b, longint c);
        return a * longint'($signed(row[15:0])) + b * longint'($signed(row[31:16]))
             + c * longint'($signed(row[47:32]));
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic project_vertex(input logic [95:0] d, input logic last);
        longint vx, vy, vz, cx, cy, cz, sx, sy, shd;
        logic [71:0] r;
        vx = $signed(d[15:0]);
        vy = $signed(d[31:16]);
        vz = $signed(d[47:32]);
        cx = row_dot(row_x, vx, vy, vz) + longint'($signed(pos_x)) * 256;
        cy = row_dot(row_y, vx, vy, vz) + longint'($signed(pos_y)) * 256;
        cz = row_dot(row_z, vx, vy, vz) + longint'($signed(pos_z)) * 256;
        sx = 0;
        sy = 0;
        if (cz > 0) begin
            sx = clip((cx * 256) / cz + SW / 2, -32768, 32767);
            sy = clip((cy * 256) / cz + SH / 2, -32768, 32767);
        end
        shd = row_dot(row_z, $signed(d[63:48]), $signed(d[79:64]), $signed(d[95:80]));
        shd = shd < 0 ? 0 : shd / 256;
        if (shd > 255) shd = 255;
        r = '0;
        r[15:0] = sx[15:0];
        r[31:16] = sy[15:0];
        r[58:32] = 27'(clip(cz, -67108864, 67108863));
        r[66:59] = shd[7:0];
        sb.note_vertex(r, cz > 0, last);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            report_mismatch(sb.check_pixel(o_m_tdata, o_m_tuser, o_m_tlast));
        if (!sink_random) begin
            i_m_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 40) == 0) begin
            sink_hold = $urandom_range(5, 30);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ROW_X: row_x = val;
            REG_ROW_Y: row_y = val;
            REG_ROW_Z: row_z = val;
            REG_OFF_X: pos_x = val[15:0];
            REG_OFF_Y: pos_y = val[15:0];
            REG_OFF_Z: pos_z = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_vertex(input logic [95:0] d, input logic last, input bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        project_vertex(d, last);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending_data.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_small();
        return 16'($signed($urandom_range(0, 1023)) - 512);
    endfunction

    function automatic logic [95:0] rand_vertex(bit wide);
        logic [95:0] d;
        for (int k = 0; k < 6; k++)
            d[16*k +: 16] = (wide || $urandom_range(0, 3) == 0) ? 16'($urandom) : rand_small();
        return d;
    endfunction

    function automatic logic [47:0] rand_row();
        logic [47:0] r;
        for (int k = 0; k < 3; k++)
            r[16*k +: 16] = $urandom_range(0, 4) == 0 ? 16'($urandom)
                                                       : 16'($signed($urandom_range(0, 512)) - 256);
        return r;
    endfunction

    initial begin
        logic [95:0] d;
        row_x = ROW_X_RST;
        row_y = ROW_Y_RST;
        row_z = ROW_Z_RST;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset identity, then extremes and corner depths.
        send_vertex({16'h7fff, 16'h7fff, 16'h7fff, 16'd100, 16'd10, 16'd20}, 1'b0, 0);
        send_vertex({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, 0);
        send_vertex({48'h7fff_7fff_7fff, 16'h7fff, 16'h8000, 16'h7fff}, 1'b1, 0);
        send_vertex({48'd0, 16'd0, 16'd0, 16'd0}, 1'b0, 0);
        send_vertex({48'h0000_0001_0000, 16'd1, 16'hffff, 16'd1}, 1'b1, 0);
        send_vertex({48'hffff_ffff_ffff, 16'h0000, 16'h8000, 16'h7fff}, 1'b0, 0);
        drain();
        write_reg(REG_ROW_X, 48'h7fff_7fff_7fff);
        write_reg(REG_ROW_Y, 48'h8000_8000_8000);
        write_reg(REG_ROW_Z, 48'h7fff_7fff_7fff);
        write_reg(REG_OFF_X, 48'h7fff);
        write_reg(REG_OFF_Y, 48'h8000);
        write_reg(REG_OFF_Z, 48'h7fff);
        write_reg(REG_NONE, 48'hffff_ffff_ffff);
        send_vertex({48'h7fff_7fff_7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b1, 0);
        send_vertex({48'h8000_8000_8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, 0);
        send_vertex({48'd1, 16'd0, 16'd0, 16'd1}, 1'b0, 0);
        drain();
        write_reg(REG_ROW_Z, 48'h8000_8000_8000);
        write_reg(REG_OFF_Z, 48'h8000);
        send_vertex({48'h7fff_7fff_7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0, 0);
        send_vertex({48'h8000_8000_8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1, 0);
        drain();
        write_reg(REG_OFF_Z, 48'h0001);
        write_reg(REG_ROW_Z, 48'h0000_0000_0000);
        send_vertex(rand_vertex(1), 1'b0, 0);
        drain();
        write_reg(REG_ROW_Z, ROW_Z_RST);
        write_reg(REG_OFF_Z, 48'd0);
        send_vertex({48'd1, 16'd0, 16'd0, 16'h7fff}, 1'b0, 0);
        send_vertex({48'h0000_0000_ffff, 16'h0000, 16'h0000, 16'h7fff}, 1'b0, 0);
        drain();

        // Random phases, each with fresh configuration.
        for (int ph = 0; ph < 10; ph++) begin
            sink_random = (ph % 4 != 3);
            write_reg(REG_ROW_X, rand_row());
            write_reg(REG_ROW_Y, rand_row());
            write_reg(REG_ROW_Z, rand_row());
            write_reg(REG_OFF_X, 48'($urandom_range(0, 1) ? 16'($urandom) : rand_small()));
            write_reg(REG_OFF_Y, 48'($urandom_range(0, 1) ? 16'($urandom) : rand_small()));
            write_reg(REG_OFF_Z, 48'($urandom_range(0, 1) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 400))));
            for (int n = 0; n < 93; n++) begin
                d = rand_vertex($urandom_range(0, 4) == 0);
                send_vertex(d, $urandom_range(0, 15) == 0, ph % 4 != 2);
            end
            drain();
        end

        if (mismatch_count == 0 && sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
